### src/lwt_pkg.sv
// Shared types and constants for the last-write tracker table.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package lwt_pkg;

  localparam int unsigned SetBitsDef  = 10;
  localparam int unsigned WaysDef     = 4;
  localparam int unsigned LookbackDef = 15;

  localparam logic [31:0] HashMul = 32'd2654435761;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned DataW  = 64;
  localparam int unsigned StampW = 64;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncQuery = 1'b1;

  // One stored record; stamp zero marks an empty way.
  typedef struct packed {
    logic [StampW-1:0] stamp;
    logic [DataW-1:0]  data;
    logic [AddrW-1:0]  len;
    logic [AddrW-1:0]  instr;
    logic [AddrW-1:0]  start;
  } way_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clr;      // write zeros to the set under the clear pointer
    logic cap;      // capture the input item
    logic issue;    // push one query candidate into the lookup pipe
    logic commit;   // write the merged set word of a write item
    logic out_ld;   // load the result registers
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clr_last;   // clear pointer at the last set
    logic cand_last;  // current candidate equals the queried address
    logic pipe_busy;  // lookup pipe still holds candidates
  } stat_t;

endpackage

`default_nettype wire

### src/lwt_hash.sv
// Multiplicative set hash with a registered product.
// Depends on lwt_pkg.
`default_nettype none

module lwt_hash
  import lwt_pkg::*;
#(
  parameter int unsigned SetBits = SetBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic [AddrW-1:0]   op_i,
  output logic      [SetBits-1:0] set_o
);

  logic [AddrW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= op_i * HashMul;
  end

  assign set_o = prod_q[AddrW-1 -: SetBits];

endmodule

`default_nettype wire

### src/lwt_dp.sv
// Datapath: input capture, set memory, way choice, query lookup pipe and result registers.
// Depends on lwt_pkg and lwt_hash.
`default_nettype none

module lwt_dp
  import lwt_pkg::*;
#(
  parameter int unsigned SetBits  = SetBitsDef,
  parameter int unsigned Ways     = WaysDef,
  parameter int unsigned Lookback = LookbackDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  output stat_t                  stat_o,
  input  wire logic              func_i,
  input  wire logic [AddrW-1:0]  addr_i,
  input  wire logic [AddrW-1:0]  write_size_i,
  input  wire logic [DataW-1:0]  write_value_i,
  input  wire logic [AddrW-1:0]  instr_addr_i,
  output logic                   found_o,
  output logic      [AddrW-1:0]  hit_addr_o,
  output logic      [AddrW-1:0]  hit_instr_o,
  output logic      [AddrW-1:0]  hit_size_o,
  output logic      [DataW-1:0]  hit_value_o
);

  localparam int unsigned Sets = 1 << SetBits;
  localparam int unsigned WayW = $clog2(Ways);

  typedef way_t [Ways-1:0] set_word_t;

  set_word_t mem_q [Sets];
  set_word_t rd_q;

  logic              func_q;
  logic [AddrW-1:0]  addr_q, size_q, instr_q, cand_q, cand1_q, cand2_q;
  logic [DataW-1:0]  value_q;
  logic [StampW-1:0] cnt_q;
  logic [SetBits-1:0] clr_q;
  logic              v1_q, v2_q;
  logic              have_q;
  way_t              best_q;

  logic [AddrW-1:0]   hash_op;
  logic [SetBits-1:0] set;

  assign hash_op = cmd_i.issue ? cand_q : addr_q;

  lwt_hash #(
    .SetBits (SetBits)
  ) u_hash (
    .clk_i (clk_i),
    .op_i  (hash_op),
    .set_o (set)
  );

  // Write item: first empty or same-address way, else oldest stamp.
  logic [WayW-1:0]   wsel;
  logic              wtaken;
  logic [StampW-1:0] wmin;
  set_word_t         wword;
  way_t              wnew;

  always_comb begin
    wsel   = '0;
    wtaken = 1'b0;
    wmin   = rd_q[0].stamp;
    for (int w = 0; w < Ways; w++) begin
      if (!wtaken) begin
        if (rd_q[w].stamp == '0 || rd_q[w].start == addr_q) begin
          wsel   = WayW'(w);
          wtaken = 1'b1;
        end else if (rd_q[w].stamp < wmin) begin
          wsel = WayW'(w);
          wmin = rd_q[w].stamp;
        end
      end
    end
    wnew.stamp = cnt_q + StampW'(1);
    wnew.data  = value_q;
    wnew.len   = size_q;
    wnew.instr = instr_q;
    wnew.start = addr_q;
    wword       = rd_q;
    wword[wsel] = wnew;
  end

  // Query lookup: newest covering record in the set of the candidate.
  // start == candidate <= query address, so only the span end needs checking.
  logic              sfound;
  way_t              sbest;
  logic              qual;

  always_comb begin
    sfound = 1'b0;
    sbest  = rd_q[0];
    for (int w = 0; w < Ways; w++) begin
      qual = rd_q[w].stamp != '0 && rd_q[w].start == cand2_q &&
             {1'b0, addr_q} < ({1'b0, rd_q[w].start} + {1'b0, rd_q[w].len});
      if (qual && (!sfound || rd_q[w].stamp > sbest.stamp)) begin
        sfound = 1'b1;
        sbest  = rd_q[w];
      end
    end
  end

  // Set memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      mem_q[clr_q] <= '0;
    end else if (cmd_i.commit) begin
      mem_q[set] <= wword;
    end
    rd_q <= mem_q[set];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      cnt_q  <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      have_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      if (cmd_i.clr) begin
        clr_q <= clr_q + SetBits'(1);
      end
      if (cmd_i.commit) begin
        cnt_q <= cnt_q + StampW'(1);
      end
      if (cmd_i.cap) begin
        have_q <= 1'b0;
      end else if (v2_q && sfound && (!have_q || sbest.stamp > best_q.stamp)) begin
        have_q <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      func_q  <= func_i;
      addr_q  <= addr_i;
      size_q  <= write_size_i;
      value_q <= write_value_i;
      instr_q <= instr_addr_i;
      cand_q  <= (addr_i >= AddrW'(Lookback)) ? addr_i - AddrW'(Lookback) : '0;
    end else if (cmd_i.issue) begin
      cand_q <= cand_q + AddrW'(1);
    end
    cand1_q <= cand_q;
    cand2_q <= cand1_q;
    if (v2_q && sfound && (!have_q || sbest.stamp > best_q.stamp)) begin
      best_q <= sbest;
    end
  end

  // Result registers.
  logic hit;
  assign hit = (func_q == FuncQuery) && have_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      found_o     <= hit;
      hit_addr_o  <= hit ? best_q.start : '0;
      hit_instr_o <= hit ? best_q.instr : '0;
      hit_size_o  <= hit ? best_q.len   : '0;
      hit_value_o <= hit ? best_q.data  : '0;
    end
  end

  assign stat_o.clr_last  = (clr_q == '1);
  assign stat_o.cand_last = (cand_q == addr_q);
  assign stat_o.pipe_busy = v1_q | v2_q;

endmodule

`default_nettype wire

### src/lwt_ctrl.sv
// Controller state machine: clear pass, write sequence, query walk, result strobe.
// Depends on lwt_pkg.
`default_nettype none

module lwt_ctrl
  import lwt_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start,
  input  wire logic  func_i,
  output logic       busy,
  output logic       done_o,
  output cmd_t       cmd_o,
  input  wire stat_t stat_i
);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StWHash,
    StWRead,
    StWWrite,
    StQIssue,
    StQDrain
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      StClear: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (start) begin
          cmd_o.cap = 1'b1;
          state_d   = (func_i == FuncQuery) ? StQIssue : StWHash;
        end
      end
      StWHash:  state_d = StWRead;
      StWRead:  state_d = StWWrite;
      StWWrite: begin
        cmd_o.commit = 1'b1;
        cmd_o.out_ld = 1'b1;
        done_d       = 1'b1;
        state_d      = StIdle;
      end
      StQIssue: begin
        cmd_o.issue = 1'b1;
        if (stat_i.cand_last) begin
          state_d = StQDrain;
        end
      end
      StQDrain: begin
        if (!stat_i.pipe_busy) begin
          cmd_o.out_ld = 1'b1;
          done_d       = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != StIdle);
  assign done_o = done_q;

endmodule

`default_nettype wire

### src/last_write_tracker_table_top.sv
// Top level of the last-write tracker table: controller plus datapath.
// Depends on lwt_pkg, lwt_ctrl, lwt_dp (and lwt_hash below it).
//
//   channel | handshake            | signals
//   --------+----------------------+-----------------------------------------------
//   item in | start && !busy       | func_i addr_i write_size_i write_value_i instr_addr_i
//   result  | done_o, one cycle    | found_o hit_addr_o hit_instr_o hit_size_o hit_value_o
//
// A write item keeps busy high after accept for the hash multiply, set read and way
// choice with set write; the result registers load with the set write. A query
// walks LOOKBACK+1 candidates (fewer near address 0) through the hash and the set
// read port, one per cycle, then drains the lookup pipe, with the result in the
// cycle after. busy is low in the result cycle, so the next item can be accepted
// at the edge that ends it. After reset a clearing pass zeroes the set memory, one
// set a cycle, with busy high.
// done_o pulses for one cycle; the receiver cannot stall it.
`default_nettype none

module last_write_tracker_table_top
  import lwt_pkg::*;
#(
  parameter int unsigned SetBits  = SetBitsDef,
  parameter int unsigned Ways     = WaysDef,
  parameter int unsigned Lookback = LookbackDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             func_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [AddrW-1:0] write_size_i,
  input  wire logic [DataW-1:0] write_value_i,
  input  wire logic [AddrW-1:0] instr_addr_i,
  output logic                  done_o,
  output logic                  found_o,
  output logic      [AddrW-1:0] hit_addr_o,
  output logic      [AddrW-1:0] hit_instr_o,
  output logic      [AddrW-1:0] hit_size_o,
  output logic      [DataW-1:0] hit_value_o
);

  cmd_t  cmd;
  stat_t stat;

  lwt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (func_i),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  lwt_dp #(
    .SetBits  (SetBits),
    .Ways     (Ways),
    .Lookback (Lookback)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .func_i        (func_i),
    .addr_i        (addr_i),
    .write_size_i  (write_size_i),
    .write_value_i (write_value_i),
    .instr_addr_i  (instr_addr_i),
    .found_o       (found_o),
    .hit_addr_o    (hit_addr_o),
    .hit_instr_o   (hit_instr_o),
    .hit_size_o    (hit_size_o),
    .hit_value_o   (hit_value_o)
  );

endmodule

`default_nettype wire

### tb/sv/last_write_tracker_table_top_tb.sv
// Self-checking testbench for last_write_tracker_table_top: directed rows, then random
// write/query traffic over hot address regions and same-set groups. Uses lwt_pkg only.
`default_nettype none

module last_write_tracker_table_top_tb;
  import lwt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumSets    = 1 << SetBitsDef;
  localparam int unsigned Depth      = NumSets * WaysDef;
  localparam int          RandItems  = 650;
  localparam int          CycleLimit = 200000;
  localparam int          NumHot     = 32;

  typedef struct packed {
    logic             found;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] instr;
    logic [AddrW-1:0] size;
    logic [DataW-1:0] value;
  } hit_t;

  typedef struct packed {
    logic             func;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] size;
    logic [DataW-1:0] value;
    logic [AddrW-1:0] instr;
    logic             fixed;  // expected hit typed in, predictor only tracks state
    hit_t             hit;
  } stim_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic             func_i;
  logic [AddrW-1:0] addr_i;
  logic [AddrW-1:0] write_size_i;
  logic [DataW-1:0] write_value_i;
  logic [AddrW-1:0] instr_addr_i;
  logic             done_o;
  logic             found_o;
  logic [AddrW-1:0] hit_addr_o;
  logic [AddrW-1:0] hit_instr_o;
  logic [AddrW-1:0] hit_size_o;
  logic [DataW-1:0] hit_value_o;

  // Shadow copy of the record store.
  logic [AddrW-1:0]  rec_start_q [Depth];
  logic [AddrW-1:0]  rec_instr_q [Depth];
  logic [AddrW-1:0]  rec_len_q   [Depth];
  logic [DataW-1:0]  rec_data_q  [Depth];
  logic [StampW-1:0] rec_stamp_q [Depth];
  logic [StampW-1:0] stamp_cnt;

  hit_t        pending_hits[$];
  stim_t       stim_rows[$];
  logic [31:0] hot_addrs[NumHot];
  logic [31:0] same_set[12];
  int          err_cnt;
  int          cyc_cnt;
  int          gap_mode_left;
  bit          no_idle;

  last_write_tracker_table_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .addr_i       (addr_i),
    .write_size_i (write_size_i),
    .write_value_i(write_value_i),
    .instr_addr_i (instr_addr_i),
    .done_o       (done_o),
    .found_o      (found_o),
    .hit_addr_o   (hit_addr_o),
    .hit_instr_o  (hit_instr_o),
    .hit_size_o   (hit_size_o),
    .hit_value_o  (hit_value_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
  end

  initial begin
    wait (cyc_cnt >= CycleLimit);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int unsigned set_of(logic [31:0] a);
    logic [31:0] h;
    h = a * HashMul;
    return h >> (32 - SetBitsDef);
  endfunction

  function automatic void store_write(stim_t s);
    int unsigned base;
    int unsigned sel;
    int unsigned e;
    bit          taken;
    base  = set_of(s.addr) * WaysDef;
    sel   = base;
    taken = 1'b0;
    for (int w = 0; w < WaysDef; w++) begin
      e = base + w;
      if (!taken) begin
        if (rec_stamp_q[e] == '0 || rec_start_q[e] == s.addr) begin
          sel   = e;
          taken = 1'b1;
        end else if (rec_stamp_q[e] < rec_stamp_q[sel]) begin
          sel = e;
        end
      end
    end
    stamp_cnt        = stamp_cnt + 1;
    rec_start_q[sel] = s.addr;
    rec_instr_q[sel] = s.instr;
    rec_len_q[sel]   = s.size;
    rec_data_q[sel]  = s.value;
    rec_stamp_q[sel] = stamp_cnt;
  endfunction

  // Newest record whose start lies in the lookback window and whose span covers q.
  function automatic hit_t newest_cover(logic [31:0] q);
    logic [31:0] lo;
    logic [31:0] cand;
    logic [32:0] span_end;
    int unsigned n;
    int unsigned e;
    int unsigned best;
    bit          have;
    hit_t        r;
    lo   = (q >= LookbackDef) ? q - LookbackDef : 32'd0;
    n    = q - lo;
    have = 1'b0;
    best = 0;
    r    = '0;
    for (int unsigned k = 0; k <= n; k++) begin
      cand = lo + k;
      for (int w = 0; w < WaysDef; w++) begin
        e        = set_of(cand) * WaysDef + w;
        span_end = {1'b0, rec_start_q[e]} + {1'b0, rec_len_q[e]};
        if (rec_stamp_q[e] != '0 && rec_start_q[e] == cand && q >= rec_start_q[e] &&
            {1'b0, q} < span_end && (!have || rec_stamp_q[e] > rec_stamp_q[best])) begin
          have = 1'b1;
          best = e;
        end
      end
    end
    if (have) begin
      r.found = 1'b1;
      r.addr  = rec_start_q[best];
      r.instr = rec_instr_q[best];
      r.size  = rec_len_q[best];
      r.value = rec_data_q[best];
    end
    return r;
  endfunction

  function automatic hit_t track_item(stim_t s);
    hit_t r;
    r = '0;
    if (s.func == FuncWrite) begin
      store_write(s);
    end else begin
      r = newest_cover(s.addr);
    end
    return r;
  endfunction

  function automatic logic [31:0] addr_in_set(int unsigned target);
    logic [31:0] a;
    a = $urandom;
    while (set_of(a) != target) a = $urandom;
    return a;
  endfunction

  task automatic add_row(logic f, logic [31:0] a, logic [31:0] sz, logic [63:0] v,
                         logic [31:0] ins, logic fx, hit_t h);
    stim_t s;
    s.func  = f;
    s.addr  = a;
    s.size  = sz;
    s.value = v;
    s.instr = ins;
    s.fixed = fx;
    s.hit   = h;
    stim_rows.push_back(s);
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    hit_t e;
    if (rst_ni && done_o) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: result with no item pending, expected none actual found=%b addr=%h",
                 $time, found_o, hit_addr_o);
        err_cnt++;
      end else begin
        e = pending_hits.pop_front();
        check_field("found", e.found, found_o);
        check_field("hit_addr", e.addr, hit_addr_o);
        check_field("hit_instr", e.instr, hit_instr_o);
        check_field("hit_size", e.size, hit_size_o);
        check_field("hit_value", e.value, hit_value_o);
      end
    end
  end

  // Drive one item and hold it until accepted; start stays high between back-to-back items.
  task automatic issue_item(stim_t s);
    int   gap;
    hit_t h;
    if (gap_mode_left == 0) begin
      no_idle       = ($urandom_range(0, 3) == 0);
      gap_mode_left = $urandom_range(10, 50);
    end
    gap_mode_left--;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    func_i        <= s.func;
    addr_i        <= s.addr;
    write_size_i  <= s.size;
    write_value_i <= s.value;
    instr_addr_i  <= s.instr;
    do @(posedge clk_i); while (busy);
    h = track_item(s);
    pending_hits.push_back(s.fixed ? s.hit : h);
  endtask

  initial begin
    stim_t s;
    hit_t  nil;
    int    pick;
    int    off;
    logic [31:0] b;

    rst_ni        <= 1'b0;
    start         <= 1'b0;
    func_i        <= FuncWrite;
    addr_i        <= '0;
    write_size_i  <= '0;
    write_value_i <= '0;
    instr_addr_i  <= '0;
    gap_mode_left = 0;
    no_idle       = 1'b0;
    stamp_cnt     = '0;
    nil           = '0;
    for (int i = 0; i < Depth; i++) begin
      rec_start_q[i] = '0;
      rec_instr_q[i] = '0;
      rec_len_q[i]   = '0;
      rec_data_q[i]  = '0;
      rec_stamp_q[i] = '0;
    end

    // Two groups of six addresses, each group sharing one set.
    b = $urandom_range(0, NumSets - 1);
    for (int i = 0; i < 6; i++) same_set[i] = addr_in_set(b);
    b = $urandom_range(0, NumSets - 1);
    for (int i = 6; i < 12; i++) same_set[i] = addr_in_set(b);
    for (int i = 0; i < NumHot; i++) begin
      if (i < 12) hot_addrs[i] = same_set[i];
      else if (i < 15) hot_addrs[i] = $urandom_range(0, 30);
      else if (i < 18) hot_addrs[i] = 32'hFFFF_FFFF - $urandom_range(0, 40);
      else hot_addrs[i] = $urandom;
    end

    // Empty store, zero-address window, end-exclusive span, zero size, span past 2^32.
    add_row(FuncQuery, 32'h0, 32'h0, 64'h0, 32'h0, 1'b1, nil);
    add_row(FuncQuery, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1, 1'b1, nil);
    add_row(FuncWrite, 32'h0, 32'd4, '1, '1, 1'b1, nil);
    add_row(FuncQuery, 32'd3, 32'h0, 64'h0, 32'h0, 1'b1,
            '{found: 1'b1, addr: 32'h0, instr: '1, size: 32'd4, value: '1});
    add_row(FuncQuery, 32'd4, 32'h0, 64'h0, 32'h0, 1'b1, nil);
    add_row(FuncWrite, 32'd10, 32'd0, 64'h1234_5678_9ABC_DEF0, 32'h0000_1000, 1'b1, nil);
    add_row(FuncQuery, 32'd10, 32'h0, 64'h0, 32'h0, 1'b1, nil);
    add_row(FuncWrite, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 64'h0, 32'h0, 1'b1, nil);
    add_row(FuncQuery, 32'hFFFF_FFFF, 32'h0, 64'h0, 32'h0, 1'b1,
            '{found: 1'b1, addr: 32'hFFFF_FFF0, instr: 32'h0, size: 32'hFFFF_FFFF,
              value: 64'h0});
    // Overlapping spans, lookback edge, rewrite of a start address, low-address window.
    add_row(FuncWrite, 32'd20, 32'd100, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b0, nil);
    add_row(FuncWrite, 32'd25, 32'd2, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 1'b0, nil);
    add_row(FuncQuery, 32'd26, 32'h0, 64'h0, 32'h0, 1'b0, nil);
    add_row(FuncQuery, 32'd40, 32'h0, 64'h0, 32'h0, 1'b0, nil);
    add_row(FuncQuery, 32'd35, 32'h0, 64'h0, 32'h0, 1'b0, nil);
    add_row(FuncWrite, 32'd20, 32'd1, 64'h0F0F_0F0F_0F0F_0F0F, 32'h0000_2000, 1'b0, nil);
    add_row(FuncQuery, 32'd35, 32'h0, 64'h0, 32'h0, 1'b0, nil);
    add_row(FuncWrite, 32'd5, 32'd20, 64'h8000_0000_0000_0001, 32'h8000_0001, 1'b0, nil);
    add_row(FuncQuery, 32'd14, 32'h0, 64'h0, 32'h0, 1'b0, nil);
    // Five writes into one set force an eviction of the oldest way.
    for (int i = 0; i < 5; i++)
      add_row(FuncWrite, same_set[i], 32'd8, {$urandom, $urandom}, $urandom, 1'b0, nil);
    add_row(FuncQuery, same_set[0], 32'h0, 64'h0, 32'h0, 1'b0, nil);
    add_row(FuncQuery, same_set[1] + 32'd3, 32'h0, 64'h0, 32'h0, 1'b0, nil);
    add_row(FuncQuery, same_set[4] + 32'd7, 32'h0, 64'h0, 32'h0, 1'b0, nil);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i]) issue_item(stim_rows[i]);

    for (int n = 0; n < RandItems; n++) begin
      s       = '0;
      s.size  = $urandom;
      s.value = {$urandom, $urandom};
      s.instr = $urandom;
      pick    = $urandom_range(0, 99);
      if (pick < 10) begin
        s.func = 1'($urandom_range(0, 1));
        s.addr = $urandom;
      end else begin
        b   = hot_addrs[$urandom_range(0, NumHot - 1)];
        off = $urandom_range(0, 1) ? 0 : $urandom_range(0, 24);
        if (pick < 55) begin
          s.func = FuncWrite;
          s.addr = b + off;
          case ($urandom_range(0, 6))
            0: s.size = $urandom_range(0, 3);
            1: ;
            default: s.size = $urandom_range(0, 24);
          endcase
        end else begin
          s.func = FuncQuery;
          s.addr = b + $urandom_range(0, 40);
        end
      end
      issue_item(s);
    end
    start <= 1'b0;

    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
